### rtl/tclg_pkg.sv
// Shared types and constants for the toroidal cell list grid.
package tclg_pkg;

  localparam int KIND_W = 3;
  localparam int COORD_W = 6;
  localparam int ID_W = 10;
  localparam int STATUS_W = 2;
  localparam int REG_ADDR_W = 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_MOVE   = 3'd2,
    KIND_CELLQ  = 3'd3,
    KIND_MOOREQ = 3'd4,
    KIND_CLEAR  = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  localparam logic [REG_ADDR_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [REG_ADDR_W-1:0] REG_HEIGHT = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_RM_CNT,
    S_RM_WAIT,
    S_RM_READ,
    S_RM_SHIFT_RD,
    S_RM_SHIFT_WR,
    S_ADD_CNT,
    S_ADD_WAIT,
    S_ADD_DO,
    S_Q_CNT,
    S_Q_WAIT,
    S_Q_SLOT,
    S_Q_EMIT,
    S_Q_NEXT,
    S_DONE
  } state_t;

endpackage

### rtl/tclg_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
module tclg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/toroidal_cell_list_grid.sv
// Top level of the toroidal cell list grid: sequencer plus count and slot memories.
//
// The grid keeps per cell an ordered list of up to CELL_CAPACITY agent ids in a
// slot memory, with the per-cell fill count in a second memory. One operation is
// handled at a time by a sequencer that reads, modifies and writes these memories,
// each read being registered. A remove searches the slots of the prior cell in order
// and shifts the slots behind the match down to close the gap, a move is a remove
// followed by an add, and a Moore query walks nine cells one after another. Clear
// sweeps the count memory one cell per cycle, and the reset performs the same sweep
// before the first item is accepted. The sequencer returns to idle after each item
// before the next beat is taken. Result beats sit in an output register, so a
// stalled result only stalls the sequencer at its next result.
module toroidal_cell_list_grid #(
  parameter int MAX_WIDTH     = 32,
  parameter int MAX_HEIGHT    = 32,
  parameter int CELL_CAPACITY = 4,
  parameter int AGENT_BITS    = 10
) (
  input  logic       clk,
  input  logic       rst,
  // input item channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] kind,
  input  logic [9:0] member_id,
  input  logic [5:0] target_x,
  input  logic [5:0] target_y,
  input  logic [5:0] prior_x,
  input  logic [5:0] prior_y,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [9:0] found_agent,
  output logic       has_agent,
  output logic [1:0] status,
  output logic       last_item,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [5:0] cfg_data
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int NCELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int CW = $clog2(NCELLS) > 0 ? $clog2(NCELLS) : 1;
  localparam int NSLOTS = NCELLS * CELL_CAPACITY;
  localparam int SW = $clog2(NSLOTS) > 0 ? $clog2(NSLOTS) : 1;
  localparam int NW = $clog2(CELL_CAPACITY + 1);
  localparam logic [NW-1:0] CAP = NW'(CELL_CAPACITY);
  localparam logic [6:0] MAXW7 = 7'(MAX_WIDTH);
  localparam logic [6:0] MAXH7 = 7'(MAX_HEIGHT);

  logic [5:0] grid_width, grid_height;

  // effective dimensions
  logic [6:0] eff_w, eff_h;
  always_comb begin
    eff_w = (grid_width == 6'd0) ? 7'd1 :
            ({1'b0, grid_width} > MAXW7) ? MAXW7 : {1'b0, grid_width};
    eff_h = (grid_height == 6'd0) ? 7'd1 :
            ({1'b0, grid_height} > MAXH7) ? MAXH7 : {1'b0, grid_height};
  end

  tclg_pkg::state_t state, state_next;

  // captured item
  logic [2:0]            op;
  logic [AGENT_BITS-1:0] id;
  logic [5:0]            tx, ty, px, py;
  tclg_pkg::status_t     st;

  // working registers
  logic [CW-1:0]         cur_cell;
  logic [NW-1:0]         cnt;
  logic [NW-1:0]         idx;
  logic [3:0]            nb;      // Moore neighbor index, dx-major
  logic                  any_out;
  logic [AGENT_BITS-1:0] slot_val;

  // memory ports
  logic          cnt_we;
  logic [CW-1:0] cnt_waddr, cnt_raddr;
  logic [NW-1:0] cnt_wdata, cnt_rdata;
  logic          slot_we;
  logic [SW-1:0] slot_waddr, slot_raddr;
  logic [AGENT_BITS-1:0] slot_wdata, slot_rdata;

  tclg_ram #(.WIDTH(NW), .DEPTH(NCELLS)) u_counts (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  tclg_ram #(.WIDTH(AGENT_BITS), .DEPTH(NSLOTS)) u_slots (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  function automatic logic [CW-1:0] cell_addr(input logic [5:0] x, input logic [5:0] y);
    logic [CW+XW-1:0] p;
    p = (CW+XW)'(x[XW-1:0]) * (CW+XW)'(MAX_HEIGHT) + (CW+XW)'(y[YW-1:0]);
    return p[CW-1:0];
  endfunction

  function automatic logic [SW-1:0] slot_addr(input logic [CW-1:0] c, input logic [NW-1:0] i);
    logic [SW+NW-1:0] p;
    p = (SW+NW)'(c) * (SW+NW)'(CELL_CAPACITY) + (SW+NW)'(i);
    return p[SW-1:0];
  endfunction

  logic tgt_in, pri_in;
  assign tgt_in = ({1'b0, tx} < eff_w) && ({1'b0, ty} < eff_h);
  assign pri_in = ({1'b0, px} < eff_w) && ({1'b0, py} < eff_h);

  // Moore neighbor coordinates, dx = nb/3 - 1, dy = nb%3 - 1
  logic [5:0] nx, ny;
  logic [1:0] dxs, dys;
  always_comb begin
    case (nb)
      4'd0, 4'd1, 4'd2: dxs = 2'd0;
      4'd3, 4'd4, 4'd5: dxs = 2'd1;
      default:          dxs = 2'd2;
    endcase
    case (nb)
      4'd0, 4'd3, 4'd6: dys = 2'd0;
      4'd1, 4'd4, 4'd7: dys = 2'd1;
      default:          dys = 2'd2;
    endcase
    case (dxs)
      2'd0:    nx = (tx == 6'd0) ? 6'(eff_w - 7'd1) : tx - 6'd1;
      2'd2:    nx = ({1'b0, tx} + 7'd1 >= eff_w) ? 6'd0 : tx + 6'd1;
      default: nx = tx;
    endcase
    case (dys)
      2'd0:    ny = (ty == 6'd0) ? 6'(eff_h - 7'd1) : ty - 6'd1;
      2'd2:    ny = ({1'b0, ty} + 7'd1 >= eff_h) ? 6'd0 : ty + 6'd1;
      default: ny = ty;
    endcase
  end

  // output register
  logic                  ob_valid;
  logic [AGENT_BITS-1:0] ob_agent;
  logic                  ob_has;
  tclg_pkg::status_t     ob_status;
  logic                  ob_last;
  logic                  emit;
  logic [AGENT_BITS-1:0] emit_agent;
  logic                  emit_has, emit_last;
  tclg_pkg::status_t     emit_status;
  logic                  ob_free;

  assign ob_free   = !ob_valid || !out_stall;
  assign out_valid = ob_valid;
  assign found_agent = 10'(ob_agent);
  assign has_agent = ob_has;
  assign status    = ob_status;
  assign last_item = ob_last;

  assign in_stall  = (state != tclg_pkg::S_IDLE);
  assign cfg_ready = (state == tclg_pkg::S_IDLE);

  logic accept;
  assign accept = in_valid && !in_stall;

  logic [CW:0] sweep;

  // sequencer
  always_comb begin
    state_next  = state;
    cnt_we      = 1'b0;
    cnt_waddr   = cur_cell;
    cnt_wdata   = '0;
    cnt_raddr   = cur_cell;
    slot_we     = 1'b0;
    slot_waddr  = slot_addr(cur_cell, idx);
    slot_wdata  = id;
    slot_raddr  = slot_addr(cur_cell, idx);
    emit        = 1'b0;
    emit_agent  = '0;
    emit_has    = 1'b0;
    emit_status = st;
    emit_last   = 1'b1;
    case (state)
      tclg_pkg::S_IDLE: begin
        if (accept) begin
          case (kind)
            tclg_pkg::KIND_ADD:    state_next = tclg_pkg::S_ADD_CNT;
            tclg_pkg::KIND_REMOVE,
            tclg_pkg::KIND_MOVE:   state_next = tclg_pkg::S_RM_CNT;
            tclg_pkg::KIND_CELLQ,
            tclg_pkg::KIND_MOOREQ: state_next = tclg_pkg::S_Q_CNT;
            tclg_pkg::KIND_CLEAR:  state_next = tclg_pkg::S_CLEAR;
            default:               state_next = tclg_pkg::S_DONE;
          endcase
        end
      end
      tclg_pkg::S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = sweep[CW-1:0];
        cnt_wdata = '0;
        if (sweep == (CW+1)'(NCELLS - 1)) begin
          state_next = (op == tclg_pkg::KIND_CLEAR) ? tclg_pkg::S_DONE : tclg_pkg::S_IDLE;
        end
      end
      // remove: read count, then scan slots
      tclg_pkg::S_RM_CNT: begin
        if (!pri_in) begin
          state_next = (op == tclg_pkg::KIND_MOVE) ? tclg_pkg::S_ADD_CNT : tclg_pkg::S_DONE;
        end else begin
          cnt_raddr  = cell_addr(px, py);
          state_next = tclg_pkg::S_RM_WAIT;
        end
      end
      tclg_pkg::S_RM_WAIT: begin
        slot_raddr = slot_addr(cur_cell, idx);
        state_next = tclg_pkg::S_RM_READ;
      end
      tclg_pkg::S_RM_READ: begin
        if (idx >= cnt) begin
          state_next = (op == tclg_pkg::KIND_MOVE) ? tclg_pkg::S_ADD_CNT : tclg_pkg::S_DONE;
        end else if (slot_rdata == id) begin
          slot_raddr = slot_addr(cur_cell, idx + NW'(1));
          state_next = tclg_pkg::S_RM_SHIFT_RD;
        end else begin
          slot_raddr = slot_addr(cur_cell, idx + NW'(1));
          state_next = tclg_pkg::S_RM_READ;
        end
      end
      tclg_pkg::S_RM_SHIFT_RD: begin
        // idx is the gap; slot idx+1 data arrives now
        if (idx + NW'(1) >= cnt) begin
          cnt_we     = 1'b1;
          cnt_waddr  = cur_cell;
          cnt_wdata  = cnt - NW'(1);
          state_next = (op == tclg_pkg::KIND_MOVE) ? tclg_pkg::S_ADD_CNT : tclg_pkg::S_DONE;
        end else begin
          slot_we    = 1'b1;
          slot_waddr = slot_addr(cur_cell, idx);
          slot_wdata = slot_rdata;
          state_next = tclg_pkg::S_RM_SHIFT_WR;
        end
      end
      tclg_pkg::S_RM_SHIFT_WR: begin
        // the gap advances to idx+1, so fetch the slot behind it
        slot_raddr = slot_addr(cur_cell, idx + NW'(2));
        state_next = tclg_pkg::S_RM_SHIFT_RD;
      end
      // add: read count, then append
      tclg_pkg::S_ADD_CNT: begin
        if (!tgt_in) begin
          state_next = tclg_pkg::S_DONE;
        end else begin
          cnt_raddr  = cell_addr(tx, ty);
          state_next = tclg_pkg::S_ADD_WAIT;
        end
      end
      tclg_pkg::S_ADD_WAIT: begin
        state_next = tclg_pkg::S_ADD_DO;
      end
      tclg_pkg::S_ADD_DO: begin
        if (cnt < CAP) begin
          slot_we    = 1'b1;
          slot_waddr = slot_addr(cur_cell, cnt);
          slot_wdata = id;
          cnt_we     = 1'b1;
          cnt_waddr  = cur_cell;
          cnt_wdata  = cnt + NW'(1);
        end
        state_next = tclg_pkg::S_DONE;
      end
      // queries: per cell read count, then slots
      tclg_pkg::S_Q_CNT: begin
        if (!tgt_in) begin
          state_next = tclg_pkg::S_DONE;
        end else begin
          cnt_raddr  = (op == tclg_pkg::KIND_MOOREQ) ? cell_addr(nx, ny) : cell_addr(tx, ty);
          state_next = tclg_pkg::S_Q_WAIT;
        end
      end
      tclg_pkg::S_Q_WAIT: begin
        slot_raddr = slot_addr(cur_cell, idx);
        state_next = tclg_pkg::S_Q_SLOT;
      end
      tclg_pkg::S_Q_SLOT: begin
        if (idx >= cnt) begin
          state_next = tclg_pkg::S_Q_NEXT;
        end else begin
          state_next = tclg_pkg::S_Q_EMIT;
        end
      end
      tclg_pkg::S_Q_EMIT: begin
        // hold one listed agent until the output register frees; last flag
        // is settled later, so emit only when the following one is known
        if (ob_free) begin
          slot_raddr = slot_addr(cur_cell, idx + NW'(1));
          state_next = tclg_pkg::S_Q_SLOT;
        end
      end
      tclg_pkg::S_Q_NEXT: begin
        if (op == tclg_pkg::KIND_MOOREQ && nb != 4'd8) begin
          state_next = tclg_pkg::S_Q_CNT;
        end else begin
          state_next = tclg_pkg::S_DONE;
        end
      end
      tclg_pkg::S_DONE: begin
        if (ob_free) begin
          emit = 1'b1;
          if (any_out) begin
            emit_agent  = slot_val;
            emit_has    = 1'b1;
            emit_status = tclg_pkg::ST_OK;
          end
          state_next = tclg_pkg::S_IDLE;
        end
      end
      default: state_next = tclg_pkg::S_IDLE;
    endcase
    // a pending listed agent goes out (not last) once another one is found
    if (state == tclg_pkg::S_Q_EMIT && ob_free && any_out) begin
      emit        = 1'b1;
      emit_agent  = slot_val;
      emit_has    = 1'b1;
      emit_status = tclg_pkg::ST_OK;
      emit_last   = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tclg_pkg::S_CLEAR;
      op          <= tclg_pkg::KIND_ADD;
      sweep       <= '0;
      grid_width  <= 6'd32;
      grid_height <= 6'd32;
      ob_valid    <= 1'b0;
      any_out     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tclg_pkg::REG_WIDTH) grid_width <= cfg_data;
        if (cfg_index == tclg_pkg::REG_HEIGHT) grid_height <= cfg_data;
      end
      if (state == tclg_pkg::S_CLEAR) begin
        sweep <= sweep + (CW+1)'(1);
      end else begin
        sweep <= '0;
      end
      if (accept) begin
        op      <= kind;
        any_out <= 1'b0;
      end
      if (state == tclg_pkg::S_Q_EMIT && ob_free) any_out <= 1'b1;
      if (state == tclg_pkg::S_DONE && ob_free) any_out <= 1'b0;
      if (emit) begin
        ob_valid <= 1'b1;
      end else if (!out_stall) begin
        ob_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (emit) begin
      ob_agent  <= emit_agent;
      ob_has    <= emit_has;
      ob_status <= emit_status;
      ob_last   <= emit_last;
    end
    if (accept) begin
      id  <= AGENT_BITS'(member_id);
      tx  <= target_x;
      ty  <= target_y;
      px  <= prior_x;
      py  <= prior_y;
      st  <= tclg_pkg::ST_OK;
      nb  <= 4'd0;
      idx <= '0;
    end
    case (state)
      tclg_pkg::S_RM_CNT: begin
        idx <= '0;
        if (!pri_in) st <= tclg_pkg::ST_RANGE;
        else cur_cell <= cell_addr(px, py);
      end
      tclg_pkg::S_RM_WAIT: cnt <= cnt_rdata;
      tclg_pkg::S_RM_READ: begin
        if (idx >= cnt) begin
          st <= tclg_pkg::ST_MISSING;
        end else if (slot_rdata != id) begin
          idx <= idx + NW'(1);
        end
      end
      tclg_pkg::S_RM_SHIFT_WR: idx <= idx + NW'(1);
      tclg_pkg::S_ADD_CNT: begin
        if (!tgt_in) begin
          if (st == tclg_pkg::ST_OK) st <= tclg_pkg::ST_RANGE;
        end else begin
          cur_cell <= cell_addr(tx, ty);
        end
      end
      tclg_pkg::S_ADD_WAIT: cnt <= cnt_rdata;
      tclg_pkg::S_ADD_DO: begin
        if (cnt >= CAP && st == tclg_pkg::ST_OK) st <= tclg_pkg::ST_FULL;
      end
      tclg_pkg::S_Q_CNT: begin
        idx <= '0;
        if (!tgt_in) st <= tclg_pkg::ST_RANGE;
        else cur_cell <= (op == tclg_pkg::KIND_MOOREQ) ? cell_addr(nx, ny)
                                                       : cell_addr(tx, ty);
      end
      tclg_pkg::S_Q_WAIT: cnt <= cnt_rdata;
      tclg_pkg::S_Q_EMIT: begin
        if (ob_free) begin
          slot_val <= slot_rdata;
          idx      <= idx + NW'(1);
        end
      end
      tclg_pkg::S_Q_NEXT: nb <= nb + 4'd1;
      default: ;
    endcase
  end

  // Slot reads in S_Q_EMIT: the data of slot idx is valid while in S_Q_SLOT/S_Q_EMIT
  // because the read address was issued in the state just before S_Q_SLOT.

  // a result beat never appears while the previous one is held unaccepted
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found_agent) && $stable(last_item))
    else $error("result beat changed while stalled");

  // items are only taken by the idle sequencer
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state != tclg_pkg::S_IDLE)
    else $error("sequencer did not leave idle on accept");

  // a beat without an agent always closes its item
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_agent |-> last_item && found_agent == 10'd0)
    else $error("marker beat not final");

  // config writes only when idle
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |-> !in_stall)
    else $error("config written while busy");

endmodule
